// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants for the stable sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_CNT_W   = 9;
    localparam int VALUE_W     = 64;
    localparam int PRIO_W      = 16;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } slot_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic  push_en;
        logic  pop_en;
        slot_t new_slot;
    } cell_ctrl_t;

endpackage

// File: src/stable_sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// priority queue held in a chain of sorted cells, stable for equal keys
// ----------------------------------------------------------------------------
// the result beat is valid in the cycle after the request beat is taken
// throughput: one request beat per cycle unless m_tready stalls the output; every cell compares and shifts at once
// reset: aresetn (sync, active low) empties the queue and drops the output beat
// slot contents are not cleared; no slot is read before it is written
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top import spq_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // [63:0] entry_value, [79:64] entry_priority
    input  logic         s_tuser,   // [0] req_type
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // [63:0] popped_value, [64] queue_empty,
                                    // [73:65] entry_count, [79:74] zero
    output logic [2:0]   m_tuser    // [0] popped_valid, [2:1] status
);

    // ------------------------------------------------------------------
    // queue occupancy and request decode
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic       accept;
    logic       is_push;
    logic       is_pop;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;

    slot_t slots      [QUEUE_DEPTH];
    logic  goes_after [QUEUE_DEPTH];

    assign accept  = s_tvalid && s_tready;
    assign is_push = accept && (s_tuser == REQ_PUSH);
    assign is_pop  = accept && (s_tuser == REQ_POP);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);

    // dropped pushes and empty pops leave the chain untouched
    assign ctrl.push_en        = is_push && !full;
    assign ctrl.pop_en         = is_pop && !empty;
    assign ctrl.new_slot.value = s_tdata[63:0];
    assign ctrl.new_slot.prio  = s_tdata[79:64];

    always_comb begin
        count_next = count_reg;
        if (ctrl.push_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop_en) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // sorted cell chain, head at index 0
    // a push: cells behind the insertion point shift one toward the tail
    // a pop: every cell takes its tail-side neighbor
    // ------------------------------------------------------------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        slot_t left_slot;
        logic  left_ga;
        slot_t right_slot;
        logic  occupied;

        assign occupied = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_head
            // head boundary: nothing ahead, so the scan stops here
            assign left_slot = ctrl.new_slot;
            assign left_ga   = 1'b1;
        end else begin : g_body
            assign left_slot = slots[i-1];
            assign left_ga   = goes_after[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_slot = slots[i];
        end else begin : g_mid
            assign right_slot = slots[i+1];
        end

        spq_cell u_cell (
            .aclk            (aclk),
            .ctrl            (ctrl),
            .occupied        (occupied),
            .left_slot       (left_slot),
            .left_goes_after (left_ga),
            .right_slot      (right_slot),
            .slot            (slots[i]),
            .goes_after      (goes_after[i])
        );
    end

    // ------------------------------------------------------------------
    // result register: takes a new beat while the old one drains
    // ------------------------------------------------------------------
    logic                     out_valid_reg;
    logic [VALUE_W-1:0]       out_value_reg;
    logic                     out_popped_reg;
    status_t                  out_status_reg;
    logic                     out_empty_reg;
    logic [OUT_CNT_W-1:0]     out_count_reg;
    logic [VALUE_W-1:0]       out_value_next;
    status_t                  out_status_next;
    logic [CNT_W+OUT_CNT_W-1:0] count_ext;

    assign s_tready  = !out_valid_reg || m_tready;
    assign count_ext = {{OUT_CNT_W{1'b0}}, count_next};

    always_comb begin
        out_value_next  = '0;
        out_status_next = ST_OK;
        if (is_push && full) begin
            out_status_next = ST_FULL;
        end else if (is_pop && empty) begin
            out_status_next = ST_EMPTY;
        end else if (ctrl.pop_en) begin
            out_value_next = slots[0].value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_value_reg  <= out_value_next;
            out_popped_reg <= ctrl.pop_en;
            out_status_reg <= out_status_next;
            out_empty_reg  <= (count_next == '0);
            out_count_reg  <= count_ext[OUT_CNT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_count_reg, out_empty_reg, out_value_reg};
    assign m_tuser  = {out_status_reg, out_popped_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_beat_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result beat");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop_en |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not shrink the queue by one");

    a_popped_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_popped_reg) |-> (out_status_reg == ST_OK && !full))
        else $error("popped entry flagged with error status");

    a_full_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == ST_FULL) |-> !out_empty_reg)
        else $error("dropped push reported an empty queue");

endmodule

// File: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, takes the new entry, or shifts
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       occupied,
    input  slot_t      left_slot,
    input  logic       left_goes_after,
    input  slot_t      right_slot,
    output slot_t      slot,
    output logic       goes_after
);

    slot_t slot_reg;
    slot_t slot_next;

    // new entry lands behind this slot when this one holds an equal or lower key
    assign goes_after = occupied && (slot_reg.prio <= ctrl.new_slot.prio);
    assign slot       = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (ctrl.push_en && !goes_after) begin
            slot_next = left_goes_after ? ctrl.new_slot : left_slot;
        end else if (ctrl.pop_en) begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule
